FILE: rtl/timed_code_sequence_alarm_defines.svh
// Assertion macros used by the timed code sequence alarm core
`ifndef TIMED_CODE_SEQUENCE_ALARM_DEFINES_SVH
`define TIMED_CODE_SEQUENCE_ALARM_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define TCSA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define TCSA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/tcsa_pkg.sv
// Types and constants of the timed code sequence alarm
package tcsa_pkg;

    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned SPACING_W  = 8;
    localparam int unsigned ALARM_W    = 16;
    localparam int unsigned PATTERN_W  = 8;
    localparam int unsigned ALARM_CNT_W = ALARM_W + 1;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_BIT_SPACING  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_ALARM_LENGTH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_CODE_PATTERN = 2'd2;

    localparam logic [SPACING_W-1:0] RST_BIT_SPACING  = 8'd50;
    localparam logic [ALARM_W-1:0]   RST_ALARM_LENGTH = 16'd5000;
    localparam logic [PATTERN_W-1:0] RST_CODE_PATTERN = 8'd203;

    typedef enum logic [1:0] {
        PH_SAMPLE  = 2'd0,
        PH_CONFIRM = 2'd1,
        PH_WAIT    = 2'd2,
        PH_ALARM   = 2'd3
    } t_phase;

    typedef struct packed {
        logic [SPACING_W-1:0] bit_spacing;
        logic [ALARM_W-1:0]   alarm_length;
        logic [PATTERN_W-1:0] code_pattern;
    } t_cfg;

    typedef struct packed {
        logic tone;
        logic alarm_on;
        logic led;
    } t_result;

endpackage

FILE: rtl/tcsa_core.sv
// Per-tick sequence matcher and alarm timer of the timed code sequence alarm
`include "timed_code_sequence_alarm_defines.svh"

module tcsa_core #(
    parameter int unsigned CODE_BITS = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  logic             i_level,
    input  tcsa_pkg::t_cfg   i_cfg,
    output tcsa_pkg::t_result o_result
);

    localparam int unsigned IDX_W = (CODE_BITS > 1) ? $clog2(CODE_BITS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CODE_BITS - 1);

    tcsa_pkg::t_phase                        r_phase, n_phase;
    logic [IDX_W-1:0]                        r_bit_idx, n_bit_idx;
    logic [tcsa_pkg::SPACING_W-1:0]          r_wait_cnt, n_wait_cnt;
    logic [tcsa_pkg::ALARM_CNT_W-1:0]        r_alarm_cnt, n_alarm_cnt;
    logic                                    r_led, n_led;

    logic [CODE_BITS-1:0]                    window;
    logic [IDX_W-1:0]                        pos;
    logic                                    match;
    logic                                    is_last;
    logic [tcsa_pkg::ALARM_CNT_W-1:0]        alarm_start;
    logic                                    alarm_out;
    logic                                    tone_out;

    assign window      = CODE_BITS'(i_cfg.code_pattern);
    assign pos         = LAST_IDX - r_bit_idx;
    assign match       = (i_level == window[pos]);
    assign is_last     = (r_bit_idx == LAST_IDX);
    assign alarm_start = {1'b0, i_cfg.alarm_length | tcsa_pkg::ALARM_W'(1)}
                         + tcsa_pkg::ALARM_CNT_W'(1);

    always_comb begin
        n_phase = r_phase;
        unique case (r_phase)
            tcsa_pkg::PH_SAMPLE: begin
                if (match) begin
                    n_phase = tcsa_pkg::PH_CONFIRM;
                end
            end
            tcsa_pkg::PH_CONFIRM: begin
                priority if (!match) begin
                    n_phase = tcsa_pkg::PH_SAMPLE;
                end else if (is_last) begin
                    n_phase = tcsa_pkg::PH_ALARM;
                end else if (i_cfg.bit_spacing == '0) begin
                    n_phase = tcsa_pkg::PH_SAMPLE;
                end else begin
                    n_phase = tcsa_pkg::PH_WAIT;
                end
            end
            tcsa_pkg::PH_WAIT: begin
                if (r_wait_cnt <= tcsa_pkg::SPACING_W'(1)) begin
                    n_phase = tcsa_pkg::PH_SAMPLE;
                end
            end
            tcsa_pkg::PH_ALARM: begin
                if (r_alarm_cnt <= tcsa_pkg::ALARM_CNT_W'(1)) begin
                    n_phase = tcsa_pkg::PH_SAMPLE;
                end
            end
            default: n_phase = tcsa_pkg::PH_SAMPLE;
        endcase
    end

    always_comb begin
        n_bit_idx   = r_bit_idx;
        n_wait_cnt  = r_wait_cnt;
        n_alarm_cnt = r_alarm_cnt;
        n_led       = r_led;
        alarm_out   = 1'b0;
        tone_out    = 1'b0;
        unique case (r_phase)
            tcsa_pkg::PH_SAMPLE: begin
                if (match) begin
                    n_led = i_level;
                end else begin
                    n_bit_idx = '0;
                end
            end
            tcsa_pkg::PH_CONFIRM: begin
                priority if (!match) begin
                    n_bit_idx = '0;
                end else if (is_last) begin
                    n_bit_idx   = '0;
                    alarm_out   = 1'b1;
                    tone_out    = ~alarm_start[0];
                    n_alarm_cnt = alarm_start - tcsa_pkg::ALARM_CNT_W'(1);
                end else begin
                    n_bit_idx = r_bit_idx + IDX_W'(1);
                    if (i_cfg.bit_spacing != '0) begin
                        n_wait_cnt = i_cfg.bit_spacing;
                    end
                end
            end
            tcsa_pkg::PH_WAIT: begin
                if (r_wait_cnt != '0) begin
                    n_wait_cnt = r_wait_cnt - tcsa_pkg::SPACING_W'(1);
                end
            end
            tcsa_pkg::PH_ALARM: begin
                if (r_alarm_cnt != '0) begin
                    alarm_out   = 1'b1;
                    tone_out    = ~r_alarm_cnt[0];
                    n_alarm_cnt = r_alarm_cnt - tcsa_pkg::ALARM_CNT_W'(1);
                end
            end
            default: n_bit_idx = '0;
        endcase
    end

    assign o_result.led      = n_led;
    assign o_result.alarm_on = alarm_out;
    assign o_result.tone     = tone_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= tcsa_pkg::PH_SAMPLE;
            r_bit_idx   <= '0;
            r_wait_cnt  <= '0;
            r_alarm_cnt <= '0;
            r_led       <= 1'b0;
        end else if (i_step) begin
            r_phase     <= n_phase;
            r_bit_idx   <= n_bit_idx;
            r_wait_cnt  <= n_wait_cnt;
            r_alarm_cnt <= n_alarm_cnt;
            r_led       <= n_led;
        end
    end

    `TCSA_ASSERT_NOW(a_tone_in_alarm, i_clk, i_rst_n,
                     o_result.tone, o_result.alarm_on, "tone outside alarm")
    `TCSA_ASSERT_NEXT(a_alarm_first_tick, i_clk, i_rst_n,
                      i_step && (r_phase == tcsa_pkg::PH_CONFIRM)
                      && (n_phase == tcsa_pkg::PH_ALARM),
                      r_alarm_cnt[0] && (r_bit_idx == '0), "alarm start count not odd")
    `TCSA_ASSERT_NOW(a_wait_nonzero, i_clk, i_rst_n,
                     r_phase == tcsa_pkg::PH_WAIT, r_wait_cnt != '0,
                     "wait phase with empty count")
    `TCSA_ASSERT_NOW(a_alarm_nonzero, i_clk, i_rst_n,
                     r_phase == tcsa_pkg::PH_ALARM, r_alarm_cnt != '0,
                     "alarm phase with empty count")

endmodule

FILE: rtl/timed_code_sequence_alarm.sv
// Top level of the timed code sequence alarm: item registers, config registers, core
//
// One input item is one receiver level sample per tick; each item gives exactly one
// result item (led, alarm_on, tone) after that tick's update. The block accepts one
// item every clock cycle while the output side does not stall: an input register
// feeds the combinational state update in the core, whose result lands in an output
// register; a stall on the output side holds the item in the input register. The
// per-tick state update (phase, bit index, wait and alarm counters) is combinational
// and sets that rate. Register writes take effect on the next item; the alarm length
// is captured when an alarm starts.
module timed_code_sequence_alarm #(
    parameter int unsigned CODE_BITS = 8
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    input  logic [7:0]                        i_s_axis_tdata,  // [0] line_level
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    output logic [7:0]                        o_m_axis_tdata,  // [0] led, [1] alarm_on, [2] tone
    input  logic                              i_cfg_we,
    input  logic [tcsa_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [tcsa_pkg::CFG_DATA_W-1:0]   i_cfg_wdata
);

    logic               r_in_valid;
    logic               r_in_level;
    logic               r_out_valid;
    tcsa_pkg::t_result  r_out;
    tcsa_pkg::t_cfg     r_cfg;
    tcsa_pkg::t_result  core_result;
    logic               step;

    assign step            = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || step;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {5'd0, r_out};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.bit_spacing  <= tcsa_pkg::RST_BIT_SPACING;
            r_cfg.alarm_length <= tcsa_pkg::RST_ALARM_LENGTH;
            r_cfg.code_pattern <= tcsa_pkg::RST_CODE_PATTERN;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                tcsa_pkg::CFG_IDX_BIT_SPACING:
                    r_cfg.bit_spacing <= i_cfg_wdata[tcsa_pkg::SPACING_W-1:0];
                tcsa_pkg::CFG_IDX_ALARM_LENGTH:
                    r_cfg.alarm_length <= i_cfg_wdata[tcsa_pkg::ALARM_W-1:0];
                tcsa_pkg::CFG_IDX_CODE_PATTERN:
                    r_cfg.code_pattern <= i_cfg_wdata[tcsa_pkg::PATTERN_W-1:0];
                default: r_cfg <= r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_s_axis_tready) begin
                r_in_valid <= i_s_axis_tvalid;
            end
            if (step) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_level <= i_s_axis_tdata[0];
        end
        if (step) begin
            r_out <= core_result;
        end
    end

    tcsa_core #(
        .CODE_BITS (CODE_BITS)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_level  (r_in_level),
        .i_cfg    (r_cfg),
        .o_result (core_result)
    );

endmodule

FILE: tb/code_alarm_monitor.sv
`timescale 1ns / 100ps
// Tracks the code sequence alarm state and checks every led/alarm/tone item it emits
module code_alarm_monitor (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    input  logic                            i_in_ready,
    input  logic [7:0]                      i_in_data,   // [0] line_level
    input  logic                            i_out_valid,
    input  logic                            i_out_ready,
    input  logic [7:0]                      i_out_data,  // [0] led, [1] alarm_on, [2] tone
    input  logic                            i_cfg_we,
    input  logic [tcsa_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [tcsa_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    output int                              o_fail_count,
    output int                              o_pending,
    output logic                            o_hunting
);

    localparam logic [2:0] LAST_BIT = 3'(tcsa_pkg::PATTERN_W - 1);

    tcsa_pkg::t_cfg                   cfg_now;
    tcsa_pkg::t_phase                 rx_phase;
    logic [2:0]                       rx_bit;
    logic [tcsa_pkg::SPACING_W-1:0]   rx_wait;
    logic [tcsa_pkg::ALARM_CNT_W-1:0] rx_alarm;
    logic                             rx_led;
    logic                             rx_tone;
    tcsa_pkg::t_result                pending_indications[$];

    task automatic flag_mismatch(input string msg);
        $display("%0t ns: mismatch: %s", $time, msg);
        o_fail_count++;
    endtask

    function automatic void ring_tick();
        rx_tone  = ~rx_alarm[0];
        rx_alarm = rx_alarm - 1'b1;
        rx_phase = tcsa_pkg::PH_ALARM;
    endfunction

    function automatic tcsa_pkg::t_result receiver_tick(input logic level);
        logic              ringing;
        logic              wanted;
        tcsa_pkg::t_result res;
        ringing = 1'b0;
        wanted  = cfg_now.code_pattern[tcsa_pkg::PATTERN_W - 1 - rx_bit];
        case (rx_phase)
            tcsa_pkg::PH_SAMPLE: begin
                if (level == wanted) begin
                    rx_led   = level;
                    rx_phase = tcsa_pkg::PH_CONFIRM;
                end else begin
                    rx_bit = '0;
                end
            end
            tcsa_pkg::PH_CONFIRM: begin
                if (level != wanted) begin
                    rx_phase = tcsa_pkg::PH_SAMPLE;
                    rx_bit   = '0;
                end else if (rx_bit == LAST_BIT) begin
                    rx_bit   = '0;
                    rx_alarm = {1'b0, cfg_now.alarm_length | 16'd1} + 1'b1;
                    ring_tick();
                    ringing = 1'b1;
                end else begin
                    rx_bit = rx_bit + 1'b1;
                    if (cfg_now.bit_spacing == '0) begin
                        rx_phase = tcsa_pkg::PH_SAMPLE;
                    end else begin
                        rx_wait  = cfg_now.bit_spacing;
                        rx_phase = tcsa_pkg::PH_WAIT;
                    end
                end
            end
            tcsa_pkg::PH_WAIT: begin
                if (rx_wait != '0) rx_wait = rx_wait - 1'b1;
                if (rx_wait == '0) rx_phase = tcsa_pkg::PH_SAMPLE;
            end
            default: begin
                if (rx_alarm == '0) begin
                    rx_phase = tcsa_pkg::PH_SAMPLE;
                    rx_tone  = 1'b0;
                end else begin
                    ring_tick();
                    ringing = 1'b1;
                end
            end
        endcase
        if (ringing && rx_alarm == '0) begin
            rx_phase = tcsa_pkg::PH_SAMPLE;
            rx_bit   = '0;
        end
        res.led      = rx_led;
        res.alarm_on = ringing;
        res.tone     = ringing & rx_tone;
        if (!ringing || rx_alarm == '0) rx_tone = 1'b0;
        return res;
    endfunction

    always @(posedge i_clk) begin : watch_channels
        tcsa_pkg::t_result got;
        tcsa_pkg::t_result wanted;
        if (!i_rst_n) begin
            cfg_now.bit_spacing  = tcsa_pkg::RST_BIT_SPACING;
            cfg_now.alarm_length = tcsa_pkg::RST_ALARM_LENGTH;
            cfg_now.code_pattern = tcsa_pkg::RST_CODE_PATTERN;
            rx_phase     = tcsa_pkg::PH_SAMPLE;
            rx_bit       = '0;
            rx_wait      = '0;
            rx_alarm     = '0;
            rx_led       = 1'b0;
            rx_tone      = 1'b0;
            o_fail_count = 0;
            pending_indications.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    tcsa_pkg::CFG_IDX_BIT_SPACING:
                        cfg_now.bit_spacing = i_cfg_wdata[tcsa_pkg::SPACING_W-1:0];
                    tcsa_pkg::CFG_IDX_ALARM_LENGTH:
                        cfg_now.alarm_length = i_cfg_wdata[tcsa_pkg::ALARM_W-1:0];
                    tcsa_pkg::CFG_IDX_CODE_PATTERN:
                        cfg_now.code_pattern = i_cfg_wdata[tcsa_pkg::PATTERN_W-1:0];
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                pending_indications.push_back(receiver_tick(i_in_data[0]));
            end
            if (i_out_valid && i_out_ready) begin
                got = tcsa_pkg::t_result'(i_out_data[2:0]);
                if (pending_indications.size() == 0) begin
                    flag_mismatch($sformatf("item %b with nothing expected", i_out_data[2:0]));
                end else begin
                    wanted = pending_indications.pop_front();
                    if (got.led !== wanted.led)
                        flag_mismatch($sformatf("led got %b expected %b", got.led, wanted.led));
                    if (got.alarm_on !== wanted.alarm_on)
                        flag_mismatch($sformatf("alarm_on got %b expected %b",
                                                got.alarm_on, wanted.alarm_on));
                    if (got.tone !== wanted.tone)
                        flag_mismatch($sformatf("tone got %b expected %b", got.tone, wanted.tone));
                end
            end
        end
        o_pending = pending_indications.size();
        o_hunting = (rx_phase == tcsa_pkg::PH_SAMPLE) && (rx_bit == '0);
    end

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 100ps
// Stimulus, clock, reset and verdict for the timed code sequence alarm
module tb_top;

    localparam logic [tcsa_pkg::CFG_IDX_W-1:0] CFG_IDX_UNUSED = 2'd3;
    localparam int ITEM_TARGET = 750;
    localparam int QUIET_AFTER = 600;

    logic                            i_clk           = 1'b0;
    logic                            i_rst_n         = 1'b0;
    logic                            i_s_axis_tvalid = 1'b0;
    logic [7:0]                      i_s_axis_tdata  = '0;
    logic                            i_m_axis_tready = 1'b0;
    logic                            i_cfg_we        = 1'b0;
    logic [tcsa_pkg::CFG_IDX_W-1:0]  i_cfg_idx       = '0;
    logic [tcsa_pkg::CFG_DATA_W-1:0] i_cfg_wdata     = '0;
    logic                            o_s_axis_tready;
    logic                            o_m_axis_tvalid;
    logic [7:0]                      o_m_axis_tdata;

    int                              fail_count;
    int                              pending;
    logic                            hunting;
    bit                              idle_on    = 1'b1;
    int                              item_count = 0;
    logic [tcsa_pkg::SPACING_W-1:0]  cur_spacing = tcsa_pkg::RST_BIT_SPACING;
    logic [tcsa_pkg::ALARM_W-1:0]    cur_alarm   = tcsa_pkg::RST_ALARM_LENGTH;
    logic [tcsa_pkg::PATTERN_W-1:0]  cur_pattern = tcsa_pkg::RST_CODE_PATTERN;

    timed_code_sequence_alarm u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),   // [0] line_level
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),   // [0] led, [1] alarm_on, [2] tone
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_wdata     (i_cfg_wdata)
    );

    code_alarm_monitor u_monitor (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_s_axis_tvalid),
        .i_in_ready   (o_s_axis_tready),
        .i_in_data    (i_s_axis_tdata),
        .i_out_valid  (o_m_axis_tvalid),
        .i_out_ready  (i_m_axis_tready),
        .i_out_data   (o_m_axis_tdata),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_wdata  (i_cfg_wdata),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_hunting    (hunting)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always begin
        @(negedge i_clk);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            i_m_axis_tready <= 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge i_clk);
        end
        i_m_axis_tready <= 1'b1;
    end

    task automatic drive_level(input logic lvl);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {7'd0, lvl};
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        @(negedge i_clk);
        item_count++;
    endtask

    task automatic write_reg(input logic [tcsa_pkg::CFG_IDX_W-1:0] idx,
                             input logic [tcsa_pkg::CFG_DATA_W-1:0] data);
        i_s_axis_tvalid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            tcsa_pkg::CFG_IDX_BIT_SPACING:  cur_spacing = data[tcsa_pkg::SPACING_W-1:0];
            tcsa_pkg::CFG_IDX_ALARM_LENGTH: cur_alarm   = data[tcsa_pkg::ALARM_W-1:0];
            tcsa_pkg::CFG_IDX_CODE_PATTERN: cur_pattern = data[tcsa_pkg::PATTERN_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_config(input logic [tcsa_pkg::SPACING_W-1:0] spacing,
                              input logic [tcsa_pkg::ALARM_W-1:0] alarm_len,
                              input logic [tcsa_pkg::PATTERN_W-1:0] pattern);
        write_reg(tcsa_pkg::CFG_IDX_BIT_SPACING, {8'($urandom), spacing});
        write_reg(tcsa_pkg::CFG_IDX_ALARM_LENGTH, alarm_len);
        write_reg(tcsa_pkg::CFG_IDX_CODE_PATTERN, {8'($urandom), pattern});
        if ($urandom_range(0, 3) == 0) write_reg(CFG_IDX_UNUSED, 16'($urandom));
    endtask

    // cut_bit < 0 plays the whole code and rides out the alarm
    task automatic play_code(input int cut_bit, input bit cut_at_confirm);
        logic lvl;
        while (!hunting) drive_level(1'($urandom_range(0, 1)));
        for (int k = 0; k < tcsa_pkg::PATTERN_W; k++) begin
            lvl = cur_pattern[tcsa_pkg::PATTERN_W - 1 - k];
            if (k == cut_bit && !cut_at_confirm) begin
                drive_level(~lvl);
                return;
            end
            drive_level(lvl);
            drive_level((k == cut_bit) ? ~lvl : lvl);
            if (k == cut_bit) return;
            if (k < tcsa_pkg::PATTERN_W - 1) begin
                repeat (cur_spacing) drive_level(1'($urandom_range(0, 1)));
            end
        end
        repeat (cur_alarm | 16'd1) drive_level(1'($urandom_range(0, 1)));
    endtask

    initial begin
        logic [tcsa_pkg::SPACING_W-1:0] gap;
        logic [tcsa_pkg::ALARM_W-1:0]   len;
        int                             pick;
        int                             plays_left;
        plays_left = 0;
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;

        play_code(1, 1'b0);
        set_config(8'd0, 16'd0, 8'h00);
        play_code(-1, 1'b0);
        drive_level(1'b1);
        drive_level(1'b1);
        set_config(8'd1, 16'd2, 8'hFF);
        play_code(3, 1'b0);
        play_code(5, 1'b1);
        play_code(-1, 1'b0);
        write_reg(CFG_IDX_UNUSED, 16'($urandom));
        set_config(8'd255, 16'd1, 8'hA5);
        play_code(1, 1'b1);
        set_config(8'd3, 16'd40, 8'h5A);
        play_code(-1, 1'b0);

        while (item_count < ITEM_TARGET) begin
            if (item_count >= QUIET_AFTER) idle_on = 1'b0;
            if (plays_left == 0) begin
                pick = $urandom_range(0, 9);
                gap  = (pick == 0) ? 8'd0 : (pick == 9) ? 8'($urandom_range(10, 20))
                                                        : 8'($urandom_range(1, 6));
                len  = ($urandom_range(0, 7) == 0) ? 16'($urandom_range(13, 60))
                                                   : 16'($urandom_range(0, 12));
                set_config(gap, len, 8'($urandom));
                plays_left = $urandom_range(2, 5);
            end
            pick = $urandom_range(0, 9);
            if (pick < 7) begin
                play_code(-1, 1'b0);
            end else if (pick == 7) begin
                play_code($urandom_range(0, tcsa_pkg::PATTERN_W - 1),
                          1'($urandom_range(0, 1)));
            end else begin
                repeat ($urandom_range(1, 12)) drive_level(1'($urandom_range(0, 1)));
            end
            plays_left--;
        end

        i_s_axis_tvalid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (10) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        #100_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule

FILE: timed_code_sequence_alarm.f
+incdir+rtl
rtl/tcsa_pkg.sv
rtl/tcsa_core.sv
rtl/timed_code_sequence_alarm.sv
tb/code_alarm_monitor.sv
tb/tb_top.sv
